/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ccbs assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, expr) \
    `ASSERT_CLK(lbl, !(expr))

`endif

/* rtl/ccbs_pkg.sv */
// Shared constants and types for the clamped cubic B-spline evaluator.
package ccbs_pkg;

    localparam int U_FRAC_BITS  = 8;
    localparam int COORD_BITS   = 16;
    localparam int NUM_POINTS   = 5;
    localparam int POINT_BITS   = 2 * COORD_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam int U_BITS  = U_FRAC_BITS + 2;
    localparam int X_BITS  = U_BITS;
    localparam int X2_BITS = 2 * X_BITS;
    localparam int X3_BITS = 3 * X_BITS;

    // weights over the common denominator 72 * S^3
    localparam int W_BITS    = 3 * U_FRAC_BITS + 7;
    localparam int WS_BITS   = W_BITS + 3;
    localparam int PROD_BITS = W_BITS + 1 + COORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    localparam longint unsigned DEN = longint'(72) << (3 * U_FRAC_BITS);
    localparam logic [W_BITS-1:0] DEN_W = W_BITS'(DEN);

    // divide by 72*S^3: shift out 8*S^3, then divide by 9 via reciprocal
    localparam int DEN_SHIFT   = 3 * U_FRAC_BITS + 3;
    localparam int Q_BITS      = COORD_BITS + 3;
    localparam int RECIP_SHIFT = COORD_BITS + 7;
    localparam int RECIP_BITS  = COORD_BITS + 5;
    localparam int RQ_BITS     = Q_BITS + RECIP_BITS;
    localparam int QUO_BITS    = RQ_BITS - RECIP_SHIFT;
    localparam longint unsigned RECIP = ((longint'(1) << RECIP_SHIFT) + 8) / 9;
    localparam logic [RECIP_BITS-1:0] RECIP_W = RECIP_BITS'(RECIP);

    localparam logic [U_BITS-1:0] ONE_S   = U_BITS'(1 << U_FRAC_BITS);
    localparam logic [U_BITS-1:0] TWO_S   = U_BITS'(2 << U_FRAC_BITS);
    localparam logic [U_BITS-1:0] THREE_S = U_BITS'(3 << U_FRAC_BITS);

    localparam logic SEG_FIRST  = 1'b0;
    localparam logic SEG_SECOND = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // accepting edge to the edge that takes the result
    localparam int PIPE_LATENCY = 9;

    typedef struct packed {
        logic                         outside;
        logic                         seg;
        logic [3:0][COORD_BITS-1:0]   px;
        logic [3:0][COORD_BITS-1:0]   py;
    } ctx_t;

    typedef struct packed {
        ctx_t                ctx;
        logic [X_BITS-1:0]   x;
        logic [X_BITS-1:0]   y;
    } item_t;

    typedef struct packed {
        ctx_t                     ctx;
        logic [3:0][W_BITS-1:0]   w;
    } weighted_t;

endpackage

/* rtl/clamped_cubic_bspline_eval.sv */
// Clamped cubic B-spline evaluator over five control points.
// done and the result word are registered at the end of the back pipeline, after the front queue.
// Throughput: one word per cycle; set by the 8-stage back pipeline of multipliers.
// busy rises only if the front queue fills, which the non-stalling back end prevents.
// Reset (rst_n low, async) clears all control points to zero and empties queue and pipeline.
module clamped_cubic_bspline_eval import ccbs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [U_BITS-1:0]            param_u,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] curve_x,
    output logic signed [COORD_BITS-1:0] curve_y,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [POINT_BITS-1:0]        cfg_data
);

    item_t     front_item;
    item_t     q_head;
    logic      q_empty;
    logic      q_full;
    logic      w_valid;
    weighted_t w_word;

    assign busy = q_full;

    ccbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .param_u   (param_u),
        .item      (front_item)
    );

    ccbs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_item (front_item),
        .pop       (!q_empty),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    ccbs_weight u_weight
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_item   (q_head),
        .out_valid (w_valid),
        .out_w     (w_word)
    );

    ccbs_combine u_combine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (w_valid),
        .in_w     (w_word),
        .done     (done),
        .curve_x  (curve_x),
        .curve_y  (curve_y)
    );

endmodule

/* rtl/ccbs_front.sv */
// Front end: control point registers, parameter classification, point selection.
module ccbs_front import ccbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [POINT_BITS-1:0]   cfg_data,
    input  logic [U_BITS-1:0]       param_u,
    output item_t                   item
);

    logic [POINT_BITS-1:0] point_reg [NUM_POINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                point_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_BITS'(NUM_POINTS)))
        begin
            point_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        item = '0;
        if (param_u < TWO_S)
        begin
            item.ctx.seg = SEG_FIRST;
            item.x       = param_u;
            item.y       = TWO_S - param_u;
        end
        else if (param_u < THREE_S)
        begin
            item.ctx.seg = SEG_SECOND;
            item.x       = param_u - TWO_S;
            item.y       = ONE_S - (param_u - TWO_S);
        end
        else
        begin
            item.ctx.outside = 1'b1;
        end

        // second segment uses points 1..4
        for (int i = 0; i < 4; i++)
        begin
            if (item.ctx.seg == SEG_SECOND)
            begin
                item.ctx.px[i] = point_reg[i + 1][COORD_BITS-1:0];
                item.ctx.py[i] = point_reg[i + 1][POINT_BITS-1:COORD_BITS];
            end
            else
            begin
                item.ctx.px[i] = point_reg[i][COORD_BITS-1:0];
                item.ctx.py[i] = point_reg[i][POINT_BITS-1:COORD_BITS];
            end
        end
    end

endmodule

/* rtl/ccbs_queue.sv */
// Short word queue between the front end and the arithmetic back end.
module ccbs_queue import ccbs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

    item_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/ccbs_weight.sv */
// Back end part one: blending weights over the common denominator, four stages.
module ccbs_weight import ccbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  item_t     in_item,
    output logic      out_valid,
    output weighted_t out_w
);

    // stage 1: squares
    logic                 v1_reg;
    ctx_t                 ctx1_reg;
    logic [X_BITS-1:0]    x1_reg;
    logic [X_BITS-1:0]    y1_reg;
    logic [X2_BITS-1:0]   xsq1_reg, xsq1_next;
    logic [X2_BITS-1:0]   ysq1_reg, ysq1_next;
    // stage 2: cubes
    logic                 v2_reg;
    ctx_t                 ctx2_reg;
    logic [X_BITS-1:0]    x2_reg;
    logic [X2_BITS-1:0]   xsq2_reg;
    logic [X3_BITS-1:0]   xcu2_reg, xcu2_next;
    logic [X3_BITS-1:0]   ycu2_reg, ycu2_next;
    // stage 3: outer weights and the second one
    logic                 v3_reg;
    ctx_t                 ctx3_reg;
    logic [W_BITS-1:0]    w0_reg, w0_next;
    logic [W_BITS-1:0]    w1_reg, w1_next;
    logic [W_BITS-1:0]    w3_reg, w3_next;
    // stage 4: remaining weight from the unit sum
    logic                 v4_reg;
    weighted_t            w4_reg, w4_next;

    logic signed [WS_BITS-1:0] x1w, x2w, x3w, y3w, w0s, w1s, w3s;

    assign xsq1_next = in_item.x * in_item.x;
    assign ysq1_next = in_item.y * in_item.y;
    assign xcu2_next = xsq1_reg * x1_reg;
    assign ycu2_next = ysq1_reg * y1_reg;

    always_comb
    begin
        x1w = WS_BITS'(x2_reg);
        x2w = WS_BITS'(xsq2_reg);
        x3w = WS_BITS'(xcu2_reg);
        y3w = WS_BITS'(ycu2_reg);
        if (ctx2_reg.seg == SEG_SECOND)
        begin
            w0s = y3w <<< 3;
            w1s = x3w * WS_BITS'(40)
                - (x2w <<< U_FRAC_BITS) * WS_BITS'(48)
                - (x1w <<< (2 * U_FRAC_BITS)) * WS_BITS'(24)
                + (WS_BITS'(32) <<< (3 * U_FRAC_BITS));
            w3s = x3w * WS_BITS'(72);
        end
        else
        begin
            w0s = (y3w <<< 3) + y3w;
            w1s = x3w * WS_BITS'(19)
                - (x2w <<< U_FRAC_BITS) * WS_BITS'(90)
                + (x1w <<< (2 * U_FRAC_BITS)) * WS_BITS'(108);
            w3s = x3w <<< 2;
        end
        w0_next = W_BITS'(w0s);
        w1_next = W_BITS'(w1s);
        w3_next = W_BITS'(w3s);
    end

    always_comb
    begin
        w4_next      = '0;
        w4_next.ctx  = ctx3_reg;
        w4_next.w[0] = w0_reg;
        w4_next.w[1] = w1_reg;
        w4_next.w[2] = DEN_W - w0_reg - w1_reg - w3_reg;
        w4_next.w[3] = w3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx1_reg <= in_item.ctx;
        x1_reg   <= in_item.x;
        y1_reg   <= in_item.y;
        xsq1_reg <= xsq1_next;
        ysq1_reg <= ysq1_next;

        ctx2_reg <= ctx1_reg;
        x2_reg   <= x1_reg;
        xsq2_reg <= xsq1_reg;
        xcu2_reg <= xcu2_next;
        ycu2_reg <= ycu2_next;

        ctx3_reg <= ctx2_reg;
        w0_reg   <= w0_next;
        w1_reg   <= w1_next;
        w3_reg   <= w3_next;

        w4_reg   <= w4_next;
    end

    assign out_valid = v4_reg;
    assign out_w     = w4_reg;

endmodule

/* rtl/ccbs_combine.sv */
// Back end part two: weighted sums, truncating divide, saturation, result register.
module ccbs_combine import ccbs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  weighted_t                    in_w,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] curve_x,
    output logic signed [COORD_BITS-1:0] curve_y
);

    localparam logic [QUO_BITS-1:0] MAX_POS = QUO_BITS'((1 << (COORD_BITS - 1)) - 1);
    localparam logic [QUO_BITS-1:0] MAX_NEG = QUO_BITS'(1 << (COORD_BITS - 1));

    function automatic logic signed [COORD_BITS-1:0] saturate(
        input logic                neg,
        input logic [QUO_BITS-1:0] quo
    );
        logic [QUO_BITS-1:0] mag;
        logic [QUO_BITS-1:0] twos;
        if (neg)
        begin
            mag  = (quo > MAX_NEG) ? MAX_NEG : quo;
            twos = ~mag + 1'b1;
            return twos[COORD_BITS-1:0];
        end
        mag = (quo > MAX_POS) ? MAX_POS : quo;
        return mag[COORD_BITS-1:0];
    endfunction

    // stage 5: products
    logic                        v5_reg;
    logic                        out5_reg;
    logic signed [PROD_BITS-1:0] prx_reg [4];
    logic signed [PROD_BITS-1:0] pry_reg [4];
    logic signed [PROD_BITS-1:0] prx_next [4];
    logic signed [PROD_BITS-1:0] pry_next [4];
    // stage 6: sums
    logic                        v6_reg;
    logic                        out6_reg;
    logic signed [SUM_BITS-1:0]  sx_reg, sx_next;
    logic signed [SUM_BITS-1:0]  sy_reg, sy_next;
    // stage 7: magnitude times reciprocal of nine
    logic                        v7_reg;
    logic                        out7_reg;
    logic                        nx_reg, ny_reg;
    logic [RQ_BITS-1:0]          rqx_reg, rqx_next;
    logic [RQ_BITS-1:0]          rqy_reg, rqy_next;
    // stage 8: result word
    logic                         done_reg;
    logic signed [COORD_BITS-1:0] curve_x_reg, curve_x_next;
    logic signed [COORD_BITS-1:0] curve_y_reg, curve_y_next;

    logic [SUM_BITS-1:0] magx, magy;
    logic [Q_BITS-1:0]   qx, qy;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prx_next[i] = $signed({1'b0, in_w.w[i]}) * $signed(in_w.ctx.px[i]);
            pry_next[i] = $signed({1'b0, in_w.w[i]}) * $signed(in_w.ctx.py[i]);
        end
    end

    assign sx_next = prx_reg[0] + prx_reg[1] + prx_reg[2] + prx_reg[3];
    assign sy_next = pry_reg[0] + pry_reg[1] + pry_reg[2] + pry_reg[3];

    // truncation toward zero: divide the magnitude, restore the sign later
    always_comb
    begin
        magx     = sx_reg[SUM_BITS-1] ? SUM_BITS'(-sx_reg) : SUM_BITS'(sx_reg);
        magy     = sy_reg[SUM_BITS-1] ? SUM_BITS'(-sy_reg) : SUM_BITS'(sy_reg);
        qx       = magx[DEN_SHIFT +: Q_BITS];
        qy       = magy[DEN_SHIFT +: Q_BITS];
        rqx_next = qx * RECIP_W;
        rqy_next = qy * RECIP_W;
    end

    always_comb
    begin
        if (out7_reg)
        begin
            curve_x_next = '0;
            curve_y_next = '0;
        end
        else
        begin
            curve_x_next = saturate(nx_reg, rqx_reg[RECIP_SHIFT +: QUO_BITS]);
            curve_y_next = saturate(ny_reg, rqy_reg[RECIP_SHIFT +: QUO_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v5_reg   <= in_valid;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            done_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out5_reg <= in_w.ctx.outside;
        for (int i = 0; i < 4; i++)
        begin
            prx_reg[i] <= prx_next[i];
            pry_reg[i] <= pry_next[i];
        end

        out6_reg <= out5_reg;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;

        out7_reg <= out6_reg;
        nx_reg   <= sx_reg[SUM_BITS-1];
        ny_reg   <= sy_reg[SUM_BITS-1];
        rqx_reg  <= rqx_next;
        rqy_reg  <= rqy_next;

        curve_x_reg <= curve_x_next;
        curve_y_reg <= curve_y_next;
    end

    assign done    = done_reg;
    assign curve_x = curve_x_reg;
    assign curve_y = curve_y_reg;

endmodule

/* rtl/ccbs_checker.sv */
// Port-level checker for the B-spline evaluator and its bind.
`include "assert_macros.svh"

module ccbs_checker import ccbs_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [U_BITS-1:0]            param_u,
    input logic                         done,
    input logic signed [COORD_BITS-1:0] curve_x,
    input logic signed [COORD_BITS-1:0] curve_y
);

    `ASSERT_NEVER(a_never_busy, busy)
    `ASSERT_CLK(a_fixed_latency, (start && !busy) |-> ##PIPE_LATENCY done)
    `ASSERT_CLK(a_no_spurious_word, done |-> $past(start && !busy, PIPE_LATENCY))
    `ASSERT_CLK(a_outside_zero, (start && !busy && (param_u >= THREE_S)) |-> ##PIPE_LATENCY (curve_x == '0 && curve_y == '0))

endmodule

bind clamped_cubic_bspline_eval ccbs_checker u_ccbs_checker (.*);
